/* sv/stepper_pulse_position_control_unit_macros.svh */
// Assertion macros used by the checker file of the step pulse unit.
`ifndef STEPPER_PULSE_POSITION_CONTROL_UNIT_MACROS_SVH
`define STEPPER_PULSE_POSITION_CONTROL_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("step pulse unit: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("step pulse unit: next-cycle check failed");

`endif

/* sv/spp_pkg.sv */
`default_nettype none

package spp_pkg;

  // Fixed field widths.
  localparam int POS_W  = 32;
  localparam int TMR_W  = 17;
  localparam int TICK_W = 16;
  localparam int BAND_W = 8;
  localparam int CFG_W  = 16;
  localparam int CIDX_W = 3;

  // Configuration register indexes.
  typedef enum logic [CIDX_W-1:0] {
    CFG_ENCODER_MODE     = 3'd0,
    CFG_PULSE_HIGH_TICKS = 3'd1,
    CFG_PULSE_GAP_TICKS  = 3'd2,
    CFG_DEADBAND         = 3'd3,
    CFG_FWD_PIN_LEVEL    = 3'd4,
    CFG_POWER_ENABLE     = 3'd5
  } cfg_idx_t;

  // Current configuration as seen by the step logic.
  typedef struct packed {
    logic              encoder_mode;
    logic [TICK_W-1:0] pulse_high_ticks;
    logic [TICK_W-1:0] pulse_gap_ticks;
    logic [BAND_W-1:0] deadband;
    logic              fwd_pin_level;
    logic              power_enable;
  } cfg_t;

  // Per-tick state of the pulse generator.
  typedef struct packed {
    logic                    pulse_level;
    logic [TMR_W-1:0]        tick_timer;
    logic                    direction_level;
    logic signed [POS_W-1:0] commanded_position;
    logic signed [POS_W-1:0] estimated_position;
  } spp_state_t;

endpackage

`default_nettype wire

/* sv/spp_cfg_regs.sv */
`default_nettype none

module spp_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [spp_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [spp_pkg::CFG_W-1:0]  cfg_data,
  output spp_pkg::cfg_t                   cfg
);

  spp_pkg::cfg_t cfg_r;
  spp_pkg::cfg_t cfg_nxt;

  // Decode the write; unknown indexes leave every register alone.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (spp_pkg::cfg_idx_t'(cfg_index))
        spp_pkg::CFG_ENCODER_MODE:     cfg_nxt.encoder_mode     = cfg_data[0];
        spp_pkg::CFG_PULSE_HIGH_TICKS: cfg_nxt.pulse_high_ticks = cfg_data;
        spp_pkg::CFG_PULSE_GAP_TICKS:  cfg_nxt.pulse_gap_ticks  = cfg_data;
        spp_pkg::CFG_DEADBAND:         cfg_nxt.deadband = cfg_data[spp_pkg::BAND_W-1:0];
        spp_pkg::CFG_FWD_PIN_LEVEL:    cfg_nxt.fwd_pin_level    = cfg_data[0];
        spp_pkg::CFG_POWER_ENABLE:     cfg_nxt.power_enable     = cfg_data[0];
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.encoder_mode     <= 1'b0;
      cfg_r.pulse_high_ticks <= spp_pkg::TICK_W'(1);
      cfg_r.pulse_gap_ticks  <= spp_pkg::TICK_W'(100);
      cfg_r.deadband         <= spp_pkg::BAND_W'(2);
      cfg_r.fwd_pin_level    <= 1'b0;
      cfg_r.power_enable     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* sv/spp_step_core.sv */
`default_nettype none

module spp_step_core (
  input  wire spp_pkg::cfg_t                    cfg,
  input  wire spp_pkg::spp_state_t              cur,
  input  wire logic signed [spp_pkg::POS_W-1:0] target_position,
  input  wire logic signed [spp_pkg::POS_W-1:0] encoder_position,
  input  wire logic                             go_forward,
  output spp_pkg::spp_state_t                   nxt
);

  localparam int XW = spp_pkg::POS_W + 2;

  logic signed [XW-1:0] tgt_x, enc_x, cmd_x, band_x, lo_x, hi_x;
  logic [spp_pkg::TMR_W-1:0] high_x, gap_x;
  logic below, above, in_band, cmd_lt_tgt, cmd_gt_tgt;
  logic pulse_done, decide;

  // Band limits are formed two bits wider so they never wrap.
  always_comb begin
    tgt_x  = XW'(target_position);
    enc_x  = XW'(encoder_position);
    cmd_x  = XW'(cur.commanded_position);
    band_x = $signed({{(XW-spp_pkg::BAND_W){1'b0}}, cfg.deadband});
    lo_x   = tgt_x - band_x;
    hi_x   = tgt_x + band_x;
    below      = enc_x < lo_x;
    above      = enc_x > hi_x;
    in_band    = (cmd_x > lo_x) && (cmd_x < hi_x);
    cmd_lt_tgt = cur.commanded_position < target_position;
    cmd_gt_tgt = cur.commanded_position > target_position;
  end

  // Timer thresholds.
  always_comb begin
    high_x     = {{(spp_pkg::TMR_W-spp_pkg::TICK_W){1'b0}}, cfg.pulse_high_ticks};
    gap_x      = {{(spp_pkg::TMR_W-spp_pkg::TICK_W){1'b0}}, cfg.pulse_gap_ticks};
    pulse_done = cur.pulse_level && (cur.tick_timer > high_x);
    decide     = !pulse_done && (cur.tick_timer > gap_x);
  end

  // One tick: drop the pulse, take a step decision, or count.
  always_comb begin
    nxt = cur;
    if (cfg.encoder_mode) begin
      nxt.estimated_position = encoder_position;
    end
    if (pulse_done) begin
      nxt.pulse_level = 1'b0;
      nxt.tick_timer  = '0;
    end else if (decide) begin
      nxt.tick_timer = '0;
      if (cfg.encoder_mode) begin
        if (below) begin
          nxt.direction_level = cfg.fwd_pin_level;
          nxt.pulse_level     = 1'b1;
          if (cfg.power_enable && cmd_lt_tgt) begin
            nxt.commanded_position = cur.commanded_position + spp_pkg::POS_W'(1);
          end
        end else if (above) begin
          nxt.direction_level = !cfg.fwd_pin_level;
          nxt.pulse_level     = 1'b1;
          if (cfg.power_enable && cmd_gt_tgt) begin
            nxt.commanded_position = cur.commanded_position - spp_pkg::POS_W'(1);
          end
        end else begin
          nxt.commanded_position = encoder_position;
        end
      end else if (!in_band) begin
        nxt.pulse_level = 1'b1;
        if (go_forward) begin
          nxt.commanded_position = cur.commanded_position + spp_pkg::POS_W'(1);
          nxt.estimated_position = cur.estimated_position + spp_pkg::POS_W'(1);
        end else begin
          nxt.commanded_position = cur.commanded_position - spp_pkg::POS_W'(1);
          nxt.estimated_position = cur.estimated_position - spp_pkg::POS_W'(1);
        end
      end
    end else begin
      nxt.tick_timer = cur.tick_timer + 1'b1;
    end
  end

endmodule

`default_nettype wire

/* sv/stepper_pulse_position_control_unit.sv */
// Step/direction pulse generator with a position deadband. Each accepted item
// is one timer tick and yields exactly one result, the pin levels and both
// position counts after that tick. An item is taken every cycle while no result
// is stalled: the step logic is combinational from the state registers, which
// also serve as the result register, so a new item enters whenever the last
// result is taken or in the same cycle it is taken. Configuration writes are
// registered before they take effect and belong in idle periods.
`default_nettype none

module stepper_pulse_position_control_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [spp_pkg::POS_W-1:0] in_target_position,
  input  wire logic signed [spp_pkg::POS_W-1:0] in_encoder_position,
  input  wire logic                             in_go_forward,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_step_level,
  output logic                                  out_dir_level,
  output logic signed [spp_pkg::POS_W-1:0]      out_commanded_count,
  output logic signed [spp_pkg::POS_W-1:0]      out_estimated_count,
  input  wire logic                             cfg_we,
  input  wire logic [spp_pkg::CIDX_W-1:0]       cfg_index,
  input  wire logic [spp_pkg::CFG_W-1:0]        cfg_data
);

  spp_pkg::cfg_t       cfg;
  spp_pkg::spp_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                accept;

  spp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  spp_step_core u_core (
    .cfg              (cfg),
    .cur              (state_r),
    .target_position  (in_target_position),
    .encoder_position (in_encoder_position),
    .go_forward       (in_go_forward),
    .nxt              (state_nxt)
  );

  // The state holds still while a result waits, so it doubles as the output.
  assign in_ready      = !out_valid_r || out_ready;
  assign accept        = in_valid && in_ready;
  assign out_valid_nxt = accept || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        state_r <= state_nxt;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_step_level      = state_r.pulse_level;
  assign out_dir_level       = state_r.direction_level;
  assign out_commanded_count = state_r.commanded_position;
  assign out_estimated_count = state_r.estimated_position;

endmodule

`default_nettype wire

/* sv/spp_checker.sv */
`default_nettype none
`include "stepper_pulse_position_control_unit_macros.svh"

module spp_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic                             out_step_level,
  input wire logic                             out_dir_level,
  input wire logic signed [spp_pkg::POS_W-1:0] out_commanded_count,
  input wire logic signed [spp_pkg::POS_W-1:0] out_estimated_count
);

  // A stalled result keeps its value.
  `SPP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_step_level) && $stable(out_commanded_count) && $stable(out_estimated_count))

  // Every accepted item produces a result in the next cycle.
  `SPP_ASSERT_NEXT(a_item_result, clk, rst_n, in_valid && in_ready, out_valid)

  // No item is taken while an untaken result would be overwritten.
  `SPP_ASSERT_NOW(a_no_overrun, clk, rst_n, out_valid && !out_ready, !in_ready)

  // Without an accepted item the direction pin and the counts do not move.
  `SPP_ASSERT_NEXT(a_idle_still, clk, rst_n, !(in_valid && in_ready), $stable(out_dir_level) && $stable(out_commanded_count) && $stable(out_estimated_count))

endmodule

bind stepper_pulse_position_control_unit spp_checker u_spp_checker (.*);

`default_nettype wire
